// ===== hw/rtl/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants for the request line parser: byte codes, verb
// and version text lookups, queue entry and result layouts.
// ----------------------------------------------------------------------------
package hrlp_pkg;

	localparam int OFF_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_VERBS = 5;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_QM = 8'h3F;
	localparam logic [7:0] CHAR_H = 8'h48;

	localparam logic [2:0] VERB_GET = 3'd0;
	localparam logic [2:0] VERB_POST = 3'd1;
	localparam logic [2:0] VERB_PATCH = 3'd2;
	localparam logic [2:0] VERB_PUT = 3'd3;
	localparam logic [2:0] VERB_DELETE = 3'd4;

	localparam logic [1:0] TERM_IDLE = 2'd0;
	localparam logic [1:0] TERM_CR = 2'd1;
	localparam logic [1:0] TERM_CRLF = 2'd2;
	localparam logic [1:0] TERM_CRLFCR = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic [OFF_W-1:0] offset;
		logic [1:0] term;
		logic done;
		logic limit_hit;
	} entry_t;

	typedef struct packed {
		logic status;
		logic [2:0] method;
		logic [OFF_W-1:0] uri_start;
		logic [OFF_W-1:0] uri_end;
		logic query_found;
		logic [OFF_W-1:0] query_start;
		logic [OFF_W-1:0] version_start;
		logic [OFF_W-1:0] version_end;
		logic [OFF_W-1:0] body_offset;
	} result_t;

	function automatic logic [2:0] verb_len(input logic [2:0] k);
		logic [2:0] len;
		case (k)
			VERB_GET: len = 3'd4;
			VERB_POST: len = 3'd5;
			VERB_PATCH: len = 3'd6;
			VERB_PUT: len = 3'd4;
			VERB_DELETE: len = 3'd7;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] verb_char(input logic [2:0] k, input logic [2:0] pos);
		logic [55:0] text;
		case (k)
			VERB_GET: text = {"GET ", 24'h0};
			VERB_POST: text = {"POST ", 16'h0};
			VERB_PATCH: text = {"PATCH ", 8'h0};
			VERB_PUT: text = {"PUT ", 24'h0};
			VERB_DELETE: text = "DELETE ";
			default: text = 56'h0;
		endcase
		return text[55 - 8 * pos -: 8];
	endfunction

	function automatic logic [7:0] ver_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = "H";
			3'd1: c = "T";
			3'd2: c = "T";
			3'd3: c = "P";
			3'd4: c = "/";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/hrlp_front.sv =====
// ----------------------------------------------------------------------------
// hrlp_front
// Input side: counts byte offsets, tracks the blank line terminator and the
// header limit, and tags each byte for the back end.
// ----------------------------------------------------------------------------
module hrlp_front #(
	parameter int LIMIT_CAP = 4095
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data,
	input  logic [11:0]          header_limit,
	output hrlp_pkg::entry_t     entry
);

	logic [hrlp_pkg::OFF_W-1:0] count_q;
	logic [1:0] term_q;
	logic [1:0] term_n;
	logic done;
	logic limit_hit;
	logic [hrlp_pkg::OFF_W:0] next_off;
	logic [hrlp_pkg::OFF_W:0] limit;

	localparam logic [hrlp_pkg::OFF_W:0] CapVal = (hrlp_pkg::OFF_W + 1)'(LIMIT_CAP);

	always_comb begin
		done = 1'b0;
		case (term_q)
			hrlp_pkg::TERM_IDLE: term_n = (data == hrlp_pkg::CHAR_CR) ?
				hrlp_pkg::TERM_CR : hrlp_pkg::TERM_IDLE;
			hrlp_pkg::TERM_CR: term_n = (data == hrlp_pkg::CHAR_LF) ? hrlp_pkg::TERM_CRLF :
				(data == hrlp_pkg::CHAR_CR) ? hrlp_pkg::TERM_CR : hrlp_pkg::TERM_IDLE;
			hrlp_pkg::TERM_CRLF: term_n = (data == hrlp_pkg::CHAR_CR) ?
				hrlp_pkg::TERM_CRLFCR : hrlp_pkg::TERM_IDLE;
			default: begin
				if (data == hrlp_pkg::CHAR_LF) begin
					done = 1'b1;
					term_n = hrlp_pkg::TERM_IDLE;
				end else begin
					term_n = (data == hrlp_pkg::CHAR_CR) ?
						hrlp_pkg::TERM_CR : hrlp_pkg::TERM_IDLE;
				end
			end
		endcase
		next_off = {1'b0, count_q} + 1'b1;
		limit = ({1'b0, header_limit} > CapVal) ? CapVal : {1'b0, header_limit};
		limit_hit = !done && (next_off >= limit);
		entry.data = data;
		entry.offset = count_q;
		entry.term = term_n;
		entry.done = done;
		entry.limit_hit = limit_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			term_q <= hrlp_pkg::TERM_IDLE;
		end else if (accept) begin
			if (done || limit_hit) begin
				count_q <= '0;
				term_q <= hrlp_pkg::TERM_IDLE;
			end else begin
				count_q <= next_off[hrlp_pkg::OFF_W-1:0];
				term_q <= term_n;
			end
		end
	end

endmodule

// ===== hw/rtl/hrlp_queue.sv =====
// ----------------------------------------------------------------------------
// hrlp_queue
// Short first-in first-out queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module hrlp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hrlp_pkg::entry_t     push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output hrlp_pkg::entry_t     head
);

	hrlp_pkg::entry_t slots_q [hrlp_pkg::QUEUE_DEPTH];
	logic [hrlp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [hrlp_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [hrlp_pkg::QUEUE_CNT_W-1:0] count_q;

	localparam logic [hrlp_pkg::QUEUE_CNT_W-1:0] Depth =
		hrlp_pkg::QUEUE_CNT_W'(hrlp_pkg::QUEUE_DEPTH);

	assign full = (count_q == Depth);
	assign not_empty = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/hrlp_back.sv =====
// ----------------------------------------------------------------------------
// hrlp_back
// Parse engine: walks method, uri, version search and header phases on each
// tagged byte and builds the result into the output register.
// ----------------------------------------------------------------------------
module hrlp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 entry_valid,
	input  hrlp_pkg::entry_t     entry,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output hrlp_pkg::result_t    result
);

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_URI,
		PH_SEEK_VER,
		PH_VERSION,
		PH_HEADERS
	} phase_t;

	localparam int OW = hrlp_pkg::OFF_W;

	phase_t phase_q, phase_n;
	logic [hrlp_pkg::NUM_VERBS-1:0] cand_q, cand_n;
	logic [2:0] tpos_q, tpos_n;
	logic [2:0] vmp_q, vmp_n;
	logic err_q, err_n;
	logic qseen_q, qseen_n;
	logic [OW-1:0] uri_start_q, uri_start_n;
	logic [OW-1:0] uri_end_q, uri_end_n;
	logic [OW-1:0] query_q, query_n;
	logic [OW-1:0] ver_start_q, ver_start_n;
	logic [OW-1:0] ver_end_q, ver_end_n;
	logic found;
	logic [2:0] method_sel;
	logic emit;
	logic bad;
	hrlp_pkg::result_t res_n;
	hrlp_pkg::result_t result_q;
	logic valid_q;

	assign pop = entry_valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result = result_q;

	always_comb begin
		phase_n = phase_q;
		cand_n = cand_q;
		tpos_n = tpos_q;
		vmp_n = vmp_q;
		err_n = err_q;
		qseen_n = qseen_q;
		uri_start_n = uri_start_q;
		uri_end_n = uri_end_q;
		query_n = query_q;
		ver_start_n = ver_start_q;
		ver_end_n = ver_end_q;
		found = 1'b0;
		if (!err_q && !entry.done) begin
			case (phase_q)
				PH_METHOD: begin
					for (int k = 0; k < hrlp_pkg::NUM_VERBS; k++) begin
						if (cand_q[k]) begin
							if (tpos_q >= hrlp_pkg::verb_len(3'(k)) ||
								hrlp_pkg::verb_char(3'(k), tpos_q) != entry.data) begin
								cand_n[k] = 1'b0;
							end else if ({1'b0, tpos_q} + 4'd1 ==
								{1'b0, hrlp_pkg::verb_len(3'(k))}) begin
								found = 1'b1;
							end
						end
					end
					if (found) begin
						uri_start_n = entry.offset + 1'b1;
						phase_n = PH_URI;
					end else if (cand_n == '0) begin
						err_n = 1'b1;
						phase_n = PH_HEADERS;
					end
					if (tpos_q != 3'd7) begin
						tpos_n = tpos_q + 1'b1;
					end
				end
				PH_URI: begin
					if (entry.data == hrlp_pkg::CHAR_SP) begin
						uri_end_n = entry.offset;
						vmp_n = '0;
						phase_n = PH_SEEK_VER;
					end else if (entry.data == hrlp_pkg::CHAR_QM && !qseen_q) begin
						qseen_n = 1'b1;
						query_n = entry.offset + 1'b1;
					end
				end
				PH_SEEK_VER: begin
					if (vmp_q < 3'd5 && entry.data == hrlp_pkg::ver_char(vmp_q)) begin
						vmp_n = vmp_q + 1'b1;
					end else begin
						vmp_n = (entry.data == hrlp_pkg::CHAR_H) ? 3'd1 : 3'd0;
					end
					if (vmp_n == 3'd5) begin
						ver_start_n = entry.offset - OW'(4);
						phase_n = PH_VERSION;
					end
				end
				PH_VERSION: begin
					if (entry.term == hrlp_pkg::TERM_CRLF) begin
						ver_end_n = entry.offset - 1'b1;
						phase_n = PH_HEADERS;
					end
				end
				default: begin
				end
			endcase
		end

		method_sel = hrlp_pkg::VERB_GET;
		for (int k = 0; k < hrlp_pkg::NUM_VERBS; k++) begin
			if (cand_q[k]) begin
				method_sel = 3'(k);
			end
		end

		emit = entry.done || entry.limit_hit;
		bad = entry.done ? (err_q || phase_q != PH_HEADERS) : 1'b1;
		res_n = '0;
		res_n.status = bad;
		if (!bad) begin
			res_n.method = method_sel;
			res_n.uri_start = uri_start_q;
			res_n.uri_end = uri_end_q;
			if (qseen_q && query_q != uri_end_q) begin
				res_n.query_found = 1'b1;
				res_n.query_start = query_q;
			end
			res_n.version_start = ver_start_q;
			res_n.version_end = ver_end_q;
			res_n.body_offset = entry.offset + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			cand_q <= '1;
			tpos_q <= '0;
			vmp_q <= '0;
			err_q <= 1'b0;
			qseen_q <= 1'b0;
			uri_start_q <= '0;
			uri_end_q <= '0;
			query_q <= '0;
			ver_start_q <= '0;
			ver_end_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (emit) begin
					phase_q <= PH_METHOD;
					cand_q <= '1;
					tpos_q <= '0;
					vmp_q <= '0;
					err_q <= 1'b0;
					qseen_q <= 1'b0;
					uri_start_q <= '0;
					uri_end_q <= '0;
					query_q <= '0;
					ver_start_q <= '0;
					ver_end_q <= '0;
				end else begin
					phase_q <= phase_n;
					cand_q <= found ? cand_n & ~(cand_n - 1'b1) : cand_n;
					tpos_q <= tpos_n;
					vmp_q <= vmp_n;
					err_q <= err_n;
					qseen_q <= qseen_n;
					uri_start_q <= uri_start_n;
					uri_end_q <= uri_end_n;
					query_q <= query_n;
					ver_start_q <= ver_start_n;
					ver_end_q <= ver_end_n;
				end
			end
			if (pop && emit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_q <= res_n;
		end
	end

endmodule

// ===== hw/rtl/http_request_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Streaming request line parser: one request byte per transaction, one
// result transaction per request at the blank line or at the header limit.
//
//   channel   direction  handshake               payload
//   data      in         data_valid/data_stall   data_byte
//   result    out        result_valid/result_stall status, method, offsets
//   cfg       in         cfg_valid/cfg_ready     header_limit
//
// one byte per cycle sustained while data_stall is low; the front counts
// offsets and tracks the terminator, a four entry queue feeds the parse
// engine, which updates its phase state once per byte and loads the output
// register and result_valid on the last byte, once it is popped from the queue.
// reset returns the parser to the method phase and the limit to 4095.
// result_stall backs up the queue; data_stall rises only when it is full.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit #(
	parameter int BUFFER_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        status,
	output logic [2:0]  method,
	output logic [11:0] uri_start,
	output logic [11:0] uri_end,
	output logic        query_found,
	output logic [11:0] query_start,
	output logic [11:0] version_start,
	output logic [11:0] version_end,
	output logic [11:0] body_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] header_limit
);

	localparam int LimitCap = (BUFFER_BYTES - 1 > 4095) ? 4095 : BUFFER_BYTES - 1;

	logic [11:0] header_limit_q;
	logic accept;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	hrlp_pkg::entry_t front_entry;
	hrlp_pkg::entry_t head_entry;
	hrlp_pkg::result_t res;

	assign cfg_ready = 1'b1;
	assign data_stall = q_full;
	assign accept = data_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= 12'd4095;
		end else if (cfg_valid && cfg_ready) begin
			header_limit_q <= header_limit;
		end
	end

	hrlp_front #(
		.LIMIT_CAP(LimitCap)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data        (data_byte),
		.header_limit(header_limit_q),
		.entry       (front_entry)
	);

	hrlp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_entry(front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_entry)
	);

	hrlp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (q_not_empty),
		.entry       (head_entry),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (res)
	);

	assign status = res.status;
	assign method = res.method;
	assign uri_start = res.uri_start;
	assign uri_end = res.uri_end;
	assign query_found = res.query_found;
	assign query_start = res.query_start;
	assign version_start = res.version_start;
	assign version_end = res.version_end;
	assign body_offset = res.body_offset;

endmodule
